FILE: rtl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg: shared types for the sorted ready queue
// Operation and status codes, fixed field widths, and the per-cell
// control and flag bundles.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IN_ID_W    = 4;
  localparam int unsigned IN_PRIO_W  = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_ID_W   = 4;
  localparam int unsigned OUT_PRIO_W = 4;
  localparam int unsigned TOTAL_W    = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_ROTATE = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    SR_OK        = 2'd0,
    SR_FULL      = 2'd1,
    SR_EMPTY     = 2'd2,
    SR_NOT_FOUND = 2'd3
  } status_e;

  // broadcast and neighbor control into one cell
  typedef struct packed {
    logic  en;         // operation commits this cycle
    func_e op;
    logic  occ;        // cell holds a queued entry
    logic  tail;       // cell is the first free slot
    logic  left_gt;    // left neighbor ranks behind the new entry
    logic  right_eqh;  // right neighbor shares the head priority
    logic  rm_shift;   // cell sits at or behind the removed entry
  } cell_ctrl_t;

  typedef struct packed {
    logic gt;     // occupied, priority worse than the pushed one
    logic match;  // occupied, id equals the given id
    logic eqh;    // occupied, priority equals the head priority
  } cell_flag_t;

endpackage

FILE: rtl/srq_if.sv
// ----------------------------------------------------------------------------
// srq_if: request and response channels of the sorted ready queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface srq_req_if;
  logic                          valid;
  logic                          ready;
  logic [srq_pkg::FUNC_W-1:0]    func;
  logic [srq_pkg::IN_ID_W-1:0]   thread_id;
  logic [srq_pkg::IN_PRIO_W-1:0] thread_priority;

  modport source (output valid, func, thread_id, thread_priority, input ready);
  modport sink   (input valid, func, thread_id, thread_priority, output ready);
endinterface

interface srq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [srq_pkg::STATUS_W-1:0]   status;
  logic [srq_pkg::OUT_ID_W-1:0]   served_thread;
  logic [srq_pkg::OUT_PRIO_W-1:0] served_priority;
  logic                           head_valid;
  logic [srq_pkg::OUT_ID_W-1:0]   head_thread;
  logic [srq_pkg::OUT_PRIO_W-1:0] head_priority;
  logic [srq_pkg::TOTAL_W-1:0]    item_total;

  modport source (output valid, status, served_thread, served_priority, head_valid,
                  head_thread, head_priority, item_total, input ready);
  modport sink   (input valid, status, served_thread, served_priority, head_valid,
                  head_thread, head_priority, item_total, output ready);
endinterface

FILE: rtl/sorted_ready_queue_with_rotate.sv
// ----------------------------------------------------------------------------
// sorted_ready_queue_with_rotate: priority-sorted thread ready queue
// Row of slot cells kept in service order; push, pop, remove and
// round-robin rotate of the head, one response beat per request beat.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------------
//  req_i    | in  | func, thread_id, thread_priority
//  rsp_o    | out | status, served thread/priority, head, item_total
//
//  A request is accepted in S_IDLE, which updates all cells at once;
//  S_REPORT then registers the response, and the response register holds
//  in S_HOLD until taken. One request is in flight; a new request is taken
//  only after the previous response beat. Reset clears the count and
//  control; slot contents need no reset.
// ----------------------------------------------------------------------------
module sorted_ready_queue_with_rotate #(
  parameter int unsigned MAX_ITEMS = 8,
  parameter int unsigned ID_BITS   = 4,
  parameter int unsigned PRIO_BITS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srq_req_if.sink   req_i,
  srq_rsp_if.source rsp_o
);
  import srq_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REPORT = 3'b010,
    S_HOLD   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [ID_BITS-1:0]   cell_tid [MAX_ITEMS];
  logic [PRIO_BITS-1:0] cell_pri [MAX_ITEMS];
  cell_flag_t           cell_flag [MAX_ITEMS];
  cell_ctrl_t           cell_ctrl [MAX_ITEMS];

  logic [MAX_ITEMS-1:0] occ, tail, gt_v, match_v, eqh_v, first_v, rm_v;

  logic [ID_BITS-1:0]   new_tid;
  logic [PRIO_BITS-1:0] new_pri;
  func_e                op;
  status_e              status;
  logic                 req_acc, op_en;

  status_e                status_q;
  logic [OUT_ID_W-1:0]    srv_tid_q, srv_tid_d;
  logic [OUT_PRIO_W-1:0]  srv_pri_q, srv_pri_d;
  logic                   hv_q;
  logic [OUT_ID_W-1:0]    htid_q;
  logic [OUT_PRIO_W-1:0]  hpri_q;
  logic [TOTAL_W-1:0]     total_q;

  assign new_tid = ID_BITS'({{ID_BITS{1'b0}}, req_i.thread_id});
  assign new_pri = PRIO_BITS'({{PRIO_BITS{1'b0}}, req_i.thread_priority});
  assign op      = func_e'(req_i.func);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      occ[i]     = CNT_W'(i) < cnt_q;
      tail[i]    = cnt_q == CNT_W'(i);
      gt_v[i]    = cell_flag[i].gt;
      match_v[i] = cell_flag[i].match;
      eqh_v[i]   = cell_flag[i].eqh;
    end
  end

  // first matching slot, then every slot at or behind it shifts up
  assign first_v = match_v & (~match_v + MAX_ITEMS'(1));
  assign rm_v    = ~(first_v - MAX_ITEMS'(1));

  always_comb begin
    status = SR_OK;
    case (op)
      FN_PUSH:   if (cnt_q == CNT_W'(MAX_ITEMS)) status = SR_FULL;
      FN_POP:    if (cnt_q == '0) status = SR_EMPTY;
      FN_REMOVE: begin
        if (cnt_q == '0)     status = SR_EMPTY;
        else if (~|match_v)  status = SR_NOT_FOUND;
      end
      FN_ROTATE: if (cnt_q == '0) status = SR_EMPTY;
      default:   status = SR_OK;
    endcase
  end

  assign op_en = req_acc && (status == SR_OK);

  always_comb begin
    cnt_d = cnt_q;
    if (op_en) begin
      case (op)
        FN_PUSH:   cnt_d = cnt_q + CNT_W'(1);
        FN_POP:    cnt_d = cnt_q - CNT_W'(1);
        FN_REMOVE: cnt_d = cnt_q - CNT_W'(1);
        default:   cnt_d = cnt_q;
      endcase
    end
  end

  always_comb begin
    srv_tid_d = '0;
    srv_pri_d = '0;
    if (op_en && (op == FN_POP || op == FN_ROTATE)) begin
      srv_tid_d = OUT_ID_W'({{OUT_ID_W{1'b0}}, cell_tid[0]});
      srv_pri_d = OUT_PRIO_W'({{OUT_PRIO_W{1'b0}}, cell_pri[0]});
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    localparam int unsigned R = (g + 1 < MAX_ITEMS) ? g + 1 : g;

    always_comb begin
      cell_ctrl[g].en        = op_en;
      cell_ctrl[g].op        = op;
      cell_ctrl[g].occ       = occ[g];
      cell_ctrl[g].tail      = tail[g];
      cell_ctrl[g].left_gt   = (g > 0) ? gt_v[(g > 0) ? g - 1 : 0] : 1'b0;
      cell_ctrl[g].right_eqh = (g + 1 < MAX_ITEMS) ? eqh_v[R] : 1'b0;
      cell_ctrl[g].rm_shift  = rm_v[g];
    end

    srq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .new_tid_i   (new_tid),
      .new_pri_i   (new_pri),
      .head_tid_i  (cell_tid[0]),
      .head_pri_i  (cell_pri[0]),
      .left_tid_i  (cell_tid[(g > 0) ? g - 1 : 0]),
      .left_pri_i  (cell_pri[(g > 0) ? g - 1 : 0]),
      .right_tid_i (cell_tid[R]),
      .right_pri_i (cell_pri[R]),
      .tid_o       (cell_tid[g]),
      .pri_o       (cell_pri[g]),
      .flag_o      (cell_flag[g])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_acc) state_d = S_REPORT;
      S_REPORT: state_d = S_HOLD;
      S_HOLD:   if (rsp_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      status_q  <= status;
      srv_tid_q <= srv_tid_d;
      srv_pri_q <= srv_pri_d;
    end
    // cells have settled by now; capture the new head
    if (state_q == S_REPORT) begin
      hv_q    <= cnt_q != '0;
      htid_q  <= (cnt_q != '0) ? OUT_ID_W'({{OUT_ID_W{1'b0}}, cell_tid[0]}) : '0;
      hpri_q  <= (cnt_q != '0) ? OUT_PRIO_W'({{OUT_PRIO_W{1'b0}}, cell_pri[0]}) : '0;
      total_q <= TOTAL_W'({{TOTAL_W{1'b0}}, cnt_q});
    end
  end

  assign rsp_o.valid           = (state_q == S_HOLD);
  assign rsp_o.status          = status_q;
  assign rsp_o.served_thread   = srv_tid_q;
  assign rsp_o.served_priority = srv_pri_q;
  assign rsp_o.head_valid      = hv_q;
  assign rsp_o.head_thread     = htid_q;
  assign rsp_o.head_priority   = hpri_q;
  assign rsp_o.item_total      = total_q;

`ifndef SYNTHESIS
  logic [MAX_ITEMS-2:0] sorted_ok;

  always_comb begin
    for (int i = 0; i + 1 < MAX_ITEMS; i++) begin
      sorted_ok[i] = !occ[i+1] || (cell_pri[i] <= cell_pri[i+1]);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("queue count above capacity");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &sorted_ok)
    else $error("occupied slots out of priority order");

  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == S_REPORT))
    else $error("request beat not followed by report cycle");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.head_valid == (cnt_q != '0)))
    else $error("head_valid disagrees with queue count");
`endif

endmodule

FILE: rtl/srq_cell.sv
// ----------------------------------------------------------------------------
// srq_cell: one slot of the sorted queue
// Holds one entry and picks its next value from itself, its left or right
// neighbor, the pushed entry or the rotated head.
// ----------------------------------------------------------------------------
module srq_cell #(
  parameter int unsigned ID_BITS   = 4,
  parameter int unsigned PRIO_BITS = 4
) (
  input  logic                   clk_i,
  input  srq_pkg::cell_ctrl_t    ctrl_i,
  input  logic [ID_BITS-1:0]     new_tid_i,
  input  logic [PRIO_BITS-1:0]   new_pri_i,
  input  logic [ID_BITS-1:0]     head_tid_i,
  input  logic [PRIO_BITS-1:0]   head_pri_i,
  input  logic [ID_BITS-1:0]     left_tid_i,
  input  logic [PRIO_BITS-1:0]   left_pri_i,
  input  logic [ID_BITS-1:0]     right_tid_i,
  input  logic [PRIO_BITS-1:0]   right_pri_i,
  output logic [ID_BITS-1:0]     tid_o,
  output logic [PRIO_BITS-1:0]   pri_o,
  output srq_pkg::cell_flag_t    flag_o
);
  import srq_pkg::*;

  logic [ID_BITS-1:0]   tid_q, tid_d;
  logic [PRIO_BITS-1:0] pri_q, pri_d;

  assign flag_o.gt    = ctrl_i.occ && (pri_q > new_pri_i);
  assign flag_o.match = ctrl_i.occ && (tid_q == new_tid_i);
  assign flag_o.eqh   = ctrl_i.occ && (pri_q == head_pri_i);

  always_comb begin
    tid_d = tid_q;
    pri_d = pri_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        FN_PUSH: begin
          if (ctrl_i.left_gt) begin
            tid_d = left_tid_i;
            pri_d = left_pri_i;
          end else if (flag_o.gt || ctrl_i.tail) begin
            tid_d = new_tid_i;
            pri_d = new_pri_i;
          end
        end
        FN_POP: begin
          tid_d = right_tid_i;
          pri_d = right_pri_i;
        end
        FN_REMOVE: begin
          if (ctrl_i.rm_shift) begin
            tid_d = right_tid_i;
            pri_d = right_pri_i;
          end
        end
        FN_ROTATE: begin
          // run of head priority slides up, head drops into the last slot of it
          if (ctrl_i.right_eqh) begin
            tid_d = right_tid_i;
            pri_d = right_pri_i;
          end else if (flag_o.eqh) begin
            tid_d = head_tid_i;
            pri_d = head_pri_i;
          end
        end
        default: begin
          tid_d = tid_q;
          pri_d = pri_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    pri_q <= pri_d;
  end

  assign tid_o = tid_q;
  assign pri_o = pri_q;

endmodule
